>>> hdl/cau_pkg.sv
// Shared types, constants and helper functions of the complex arithmetic unit.
// Used by cau_iter and complex_arithmetic_unit_top; depends on nothing else.
package cau_pkg;

    // Word format: signed Q(WB-FB).FB
    localparam int WB = 32;
    localparam int FB = 16;
    localparam int PW = 2 * WB;          // full product width
    localparam int SW = PW + 2;          // headroom width for saturation
    localparam int NS = WB + 1;          // quotient bits, one per stage
    localparam int SH = WB + 1 - FB;     // numerator shift ahead of the divide
    localparam int TOL_BITS = 16;
    localparam int MIN_BITS = 32;
    localparam int CFG_BITS = 32;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_NEG   = 4'd4,
        OP_EQ    = 4'd5,
        OP_NEQ   = 4'd6,
        OP_L1    = 4'd7,
        OP_MAG   = 4'd8,
        OP_SQMAG = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_EQ_TOL  = 1'd0,
        CFG_DIV_MIN = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic        [3:0]    operation;
        logic signed [WB-1:0] a_real;
        logic signed [WB-1:0] a_imag;
        logic signed [WB-1:0] b_real;
        logic signed [WB-1:0] b_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [WB-1:0] res_real;
        logic signed [WB-1:0] res_imag;
        logic        [WB-1:0] scalar_out;
        logic                 compare_true;
        logic        [1:0]    status;
    } t_out_item;

    // Item data that rides along the divide / square root stages
    typedef struct packed {
        logic [3:0] op;
        t_out_item  early;
        logic       dz;
        logic       ovf_r;
        logic       ovf_i;
        logic       neg_r;
        logic       neg_i;
    } t_side;

    // Working state of the two divide lanes and the square root lane
    typedef struct packed {
        logic [PW-1:0] den;
        logic [PW-1:0] rem_r;
        logic [PW-1:0] rem_i;
        logic [WB:0]   nlo_r;
        logic [WB:0]   nlo_i;
        logic [WB:0]   q_r;
        logic [WB:0]   q_i;
        logic [PW-1:0] srem;
        logic [WB-1:0] root;
    } t_lanes;

    typedef struct packed {
        logic [WB-1:0] val;
        logic          sat;
    } t_sat;

    localparam logic signed [SW-1:0] SMAX = {{(SW-WB+1){1'b0}}, {(WB-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-WB+1){1'b1}}, {(WB-1){1'b0}}};
    localparam logic [SW-1:0]        UMAX = {{(SW-WB){1'b0}}, {WB{1'b1}}};

    function automatic logic signed [SW-1:0] sext(input logic [WB-1:0] x);
        return {{(SW-WB){x[WB-1]}}, x};
    endfunction

    function automatic logic [SW-1:0] abs_s(input logic signed [SW-1:0] x);
        return (x < 0) ? $unsigned(-x) : $unsigned(x);
    endfunction

    // Clamp a signed value to the word range
    function automatic t_sat sat_signed(input logic signed [SW-1:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[WB-1:0];
        if (v > SMAX) begin
            r.sat = 1'b1;
            r.val = SMAX[WB-1:0];
        end else if (v < SMIN) begin
            r.sat = 1'b1;
            r.val = SMIN[WB-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/cau_iter.sv
// Restoring divide (two lanes) and square root pipeline, one result bit per stage.
// Depends on cau_pkg.
module cau_iter
    import cau_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_side  i_side,
    input  t_lanes i_lanes,
    output logic   o_valid,
    output t_side  o_side,
    output t_lanes o_lanes
);

    logic   r_valid [0:NS-1];
    t_side  r_side  [0:NS-1];
    t_lanes r_lanes [0:NS-1];
    t_lanes w_prev  [0:NS-1];
    t_lanes n_lanes [0:NS-1];

    assign w_prev[0] = i_lanes;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [PW:0] tr_r;
        logic [PW:0] tr_i;

        if (g > 0) begin : g_link
            assign w_prev[g] = r_lanes[g-1];
        end

        // Divide step: shift in one numerator bit, subtract if it fits
        always_comb begin
            n_lanes[g] = w_prev[g];
            tr_r = {w_prev[g].rem_r, w_prev[g].nlo_r[WB]};
            tr_i = {w_prev[g].rem_i, w_prev[g].nlo_i[WB]};
            n_lanes[g].nlo_r = {w_prev[g].nlo_r[WB-1:0], 1'b0};
            n_lanes[g].nlo_i = {w_prev[g].nlo_i[WB-1:0], 1'b0};
            if (tr_r >= {1'b0, w_prev[g].den}) begin
                n_lanes[g].rem_r = PW'(tr_r - {1'b0, w_prev[g].den});
                n_lanes[g].q_r   = {w_prev[g].q_r[WB-1:0], 1'b1};
            end else begin
                n_lanes[g].rem_r = PW'(tr_r);
                n_lanes[g].q_r   = {w_prev[g].q_r[WB-1:0], 1'b0};
            end
            if (tr_i >= {1'b0, w_prev[g].den}) begin
                n_lanes[g].rem_i = PW'(tr_i - {1'b0, w_prev[g].den});
                n_lanes[g].q_i   = {w_prev[g].q_i[WB-1:0], 1'b1};
            end else begin
                n_lanes[g].rem_i = PW'(tr_i);
                n_lanes[g].q_i   = {w_prev[g].q_i[WB-1:0], 1'b0};
            end
        end

        // Square root step for root bit K; the last stage has none
        if (g < WB) begin : g_sqrt
            localparam int K = WB - 1 - g;
            logic [PW:0] trial;
            assign trial = ({{(PW+1-WB){1'b0}}, w_prev[g].root} << (K + 1))
                         | ({{PW{1'b0}}, 1'b1} << (2 * K));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if ({1'b0, w_prev[g].srem} >= trial) begin
                        r_lanes[g].srem    <= PW'({1'b0, w_prev[g].srem} - trial);
                        r_lanes[g].root    <= w_prev[g].root | (WB'(1) << K);
                    end else begin
                        r_lanes[g].srem    <= w_prev[g].srem;
                        r_lanes[g].root    <= w_prev[g].root;
                    end
                end
            end
        end else begin : g_nosqrt
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lanes[g].srem <= w_prev[g].srem;
                    r_lanes[g].root <= w_prev[g].root;
                end
            end
        end

        // Advance lanes and side data
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lanes[g].den   <= n_lanes[g].den;
                r_lanes[g].rem_r <= n_lanes[g].rem_r;
                r_lanes[g].rem_i <= n_lanes[g].rem_i;
                r_lanes[g].nlo_r <= n_lanes[g].nlo_r;
                r_lanes[g].nlo_i <= n_lanes[g].nlo_i;
                r_lanes[g].q_r   <= n_lanes[g].q_r;
                r_lanes[g].q_i   <= n_lanes[g].q_i;
                r_side[g]        <= (g == 0) ? i_side : r_side[(g == 0) ? 0 : g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= (g == 0) ? i_valid : r_valid[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_lanes = r_lanes[NS-1];

endmodule

>>> hdl/complex_arithmetic_unit_top.sv
// Complex arithmetic unit, top level: skid stage, front stages, result stage.
// Depends on cau_pkg and cau_iter.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one t_in_item per transfer:
//   an operation code and two complex operands in signed Q16.16.
//   Output channel o_out_valid / i_out_stall carries one t_out_item per item:
//   complex result, scalar result, compare flag and status.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 equality tolerance, 1 divide minimum norm). Write only while idle.
// Timing:
//   From the input transfer to output valid: the
//   transfer loads the input register, then the multiply stage, add stage,
//   divide setup stage, 33 divide / square root stages (one quotient bit per
//   stage) and the output register follow.
//   Throughput is one item per cycle while the output is not stalled; the
//   restoring divider stage chain sets the depth.
// Reset and stall:
//   Reset empties the pipeline and sets tolerance 0, minimum norm 1.
//   While the output is stalled the whole pipeline holds; one further input
//   transfer lands in the skid register and then o_in_stall rises.
module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    logic                r_sk_valid;
    t_in_item            r_sk_item;
    logic                r_a_valid;
    t_in_item            r_a_item;
    logic                r_b_valid;
    logic [3:0]          r_b_op;
    t_out_item           r_b_early;
    logic signed [PW-1:0] r_b_p0, r_b_p1, r_b_p2, r_b_p3, r_b_p4, r_b_p5;
    logic                r_c_valid;
    logic [3:0]          r_c_op;
    t_out_item           r_c_early;
    logic signed [PW:0]  r_c_s01, r_c_mr, r_c_mi, r_c_di;
    logic [PW-1:0]       r_c_den;
    logic                r_d_valid;
    t_side               r_d_side;
    t_lanes              r_d_lanes;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [TOL_BITS-1:0] r_eq_tol;
    logic [MIN_BITS-1:0] r_min_norm;

    logic                en;
    logic                in_xfer;
    t_out_item           n_b_early;
    t_side               n_d_side;
    t_lanes              n_d_lanes;
    t_out_item           n_out_item;
    logic                it_valid;
    t_side               it_side;
    t_lanes              it_lanes;

    assign en         = !(r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !r_sk_valid;
    assign o_in_stall = r_sk_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eq_tol   <= '0;
            r_min_norm <= MIN_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EQ_TOL:  r_eq_tol   <= i_cfg_data[TOL_BITS-1:0];
                CFG_DIV_MIN: r_min_norm <= i_cfg_data[MIN_BITS-1:0];
                default:     r_eq_tol   <= r_eq_tol;
            endcase
        end
    end

    // Skid register and input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
            r_a_valid  <= 1'b0;
        end else if (en) begin
            r_sk_valid <= 1'b0;
            r_a_valid  <= r_sk_valid || in_xfer;
        end else if (in_xfer) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item <= r_sk_valid ? r_sk_item : i_in_item;
        end else if (in_xfer) begin
            r_sk_item <= i_in_item;
        end
    end

    // Early results: add, subtract, negate, compares, L1 norm
    always_comb begin
        logic signed [SW-1:0] ar, ai, br, bi;
        logic signed [SW-1:0] vr, vi;
        logic [SW-1:0]        dr, di, l1;
        logic [SW-1:0]        tol;
        t_sat                 sr, si;
        ar  = sext(r_a_item.a_real);
        ai  = sext(r_a_item.a_imag);
        br  = sext(r_a_item.b_real);
        bi  = sext(r_a_item.b_imag);
        tol = {{(SW-TOL_BITS){1'b0}}, r_eq_tol};
        dr  = abs_s(ar - br);
        di  = abs_s(ai - bi);
        l1  = abs_s(ar) + abs_s(ai);
        vr  = ar + br;
        vi  = ai + bi;
        case (r_a_item.operation)
            OP_SUB: begin
                vr = ar - br;
                vi = ai - bi;
            end
            OP_NEG: begin
                vr = -ar;
                vi = -ai;
            end
            default: begin
                vr = ar + br;
                vi = ai + bi;
            end
        endcase
        sr = sat_signed(vr);
        si = sat_signed(vi);
        n_b_early = '0;
        case (r_a_item.operation)
            OP_ADD, OP_SUB, OP_NEG: begin
                n_b_early.res_real = sr.val;
                n_b_early.res_imag = si.val;
                n_b_early.status   = (sr.sat || si.sat) ? ST_SAT : ST_OK;
            end
            OP_EQ:  n_b_early.compare_true = (dr < tol) && (di < tol);
            OP_NEQ: n_b_early.compare_true = (dr > tol) || (di > tol);
            OP_L1: begin
                if (l1 > UMAX) begin
                    n_b_early.scalar_out = UMAX[WB-1:0];
                    n_b_early.status     = ST_SAT;
                end else begin
                    n_b_early.scalar_out = l1[WB-1:0];
                end
            end
            default: n_b_early = '0;
        endcase
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        logic sq;
        sq = (r_a_item.operation == OP_MAG) || (r_a_item.operation == OP_SQMAG);
        if (en) begin
            r_b_op    <= r_a_item.operation;
            r_b_early <= n_b_early;
            r_b_p0    <= r_a_item.a_real * (sq ? r_a_item.a_real : r_a_item.b_real);
            r_b_p1    <= r_a_item.a_imag * (sq ? r_a_item.a_imag : r_a_item.b_imag);
            r_b_p2    <= r_a_item.a_real * r_a_item.b_imag;
            r_b_p3    <= r_a_item.a_imag * r_a_item.b_real;
            r_b_p4    <= r_a_item.b_real * r_a_item.b_real;
            r_b_p5    <= r_a_item.b_imag * r_a_item.b_imag;
        end
    end

    // Product sum stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_op    <= r_b_op;
            r_c_early <= r_b_early;
            r_c_s01   <= {r_b_p0[PW-1], r_b_p0} + {r_b_p1[PW-1], r_b_p1};
            r_c_mr    <= {r_b_p0[PW-1], r_b_p0} - {r_b_p1[PW-1], r_b_p1};
            r_c_mi    <= {r_b_p2[PW-1], r_b_p2} + {r_b_p3[PW-1], r_b_p3};
            r_c_di    <= {r_b_p3[PW-1], r_b_p3} - {r_b_p2[PW-1], r_b_p2};
            r_c_den   <= $unsigned(r_b_p4) + $unsigned(r_b_p5);
        end
    end

    // Finish multiply and squared magnitude, set up divide and square root
    always_comb begin
        logic signed [PW:0] shr, shi;
        logic [PW:0]        sqs;
        logic [PW-1:0]      num_r, num_i;
        t_sat               sr, si;
        shr   = r_c_mr >>> FB;
        shi   = r_c_mi >>> FB;
        sqs   = $unsigned(r_c_s01) >> FB;
        sr    = sat_signed({shr[PW], shr});
        si    = sat_signed({shi[PW], shi});
        num_r = PW'(r_c_s01[PW] ? $unsigned(-r_c_s01) : $unsigned(r_c_s01));
        num_i = PW'(r_c_di[PW] ? $unsigned(-r_c_di) : $unsigned(r_c_di));

        n_d_side       = '0;
        n_d_side.op    = r_c_op;
        n_d_side.early = r_c_early;
        case (r_c_op)
            OP_MUL: begin
                n_d_side.early.res_real = sr.val;
                n_d_side.early.res_imag = si.val;
                n_d_side.early.status   = (sr.sat || si.sat) ? ST_SAT : ST_OK;
            end
            OP_SQMAG: begin
                if (sqs[PW:WB] != '0) begin
                    n_d_side.early.scalar_out = UMAX[WB-1:0];
                    n_d_side.early.status     = ST_SAT;
                end else begin
                    n_d_side.early.scalar_out = sqs[WB-1:0];
                end
            end
            default: n_d_side.early = r_c_early;
        endcase
        n_d_side.dz    = (r_c_den == '0) || (r_c_den < PW'(r_min_norm));
        n_d_side.neg_r = r_c_s01[PW];
        n_d_side.neg_i = r_c_di[PW];
        n_d_side.ovf_r = (num_r >> SH) >= r_c_den;
        n_d_side.ovf_i = (num_i >> SH) >= r_c_den;

        n_d_lanes       = '0;
        n_d_lanes.den   = r_c_den;
        n_d_lanes.rem_r = num_r >> SH;
        n_d_lanes.rem_i = num_i >> SH;
        n_d_lanes.nlo_r = {num_r[SH-1:0], {FB{1'b0}}};
        n_d_lanes.nlo_i = {num_i[SH-1:0], {FB{1'b0}}};
        n_d_lanes.srem  = r_c_s01[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side  <= n_d_side;
            r_d_lanes <= n_d_lanes;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    cau_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_side  (r_d_side),
        .i_lanes (r_d_lanes),
        .o_valid (it_valid),
        .o_side  (it_side),
        .o_lanes (it_lanes)
    );

    // Assemble the result: quotient sign and clamp, or root, or early result
    always_comb begin
        logic signed [SW-1:0] vr, vi;
        t_sat                 sr, si;
        vr = it_side.neg_r ? -$signed({{(SW-WB-1){1'b0}}, it_lanes.q_r})
                           :  $signed({{(SW-WB-1){1'b0}}, it_lanes.q_r});
        vi = it_side.neg_i ? -$signed({{(SW-WB-1){1'b0}}, it_lanes.q_i})
                           :  $signed({{(SW-WB-1){1'b0}}, it_lanes.q_i});
        sr = sat_signed(vr);
        si = sat_signed(vi);
        if (it_side.ovf_r) begin
            sr.sat = 1'b1;
            sr.val = it_side.neg_r ? SMIN[WB-1:0] : SMAX[WB-1:0];
        end
        if (it_side.ovf_i) begin
            si.sat = 1'b1;
            si.val = it_side.neg_i ? SMIN[WB-1:0] : SMAX[WB-1:0];
        end
        n_out_item = '0;
        case (it_side.op)
            OP_DIV: begin
                if (it_side.dz) begin
                    n_out_item.status = ST_DIV_ZERO;
                end else begin
                    n_out_item.res_real = sr.val;
                    n_out_item.res_imag = si.val;
                    n_out_item.status   = (sr.sat || si.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG:  n_out_item.scalar_out = it_lanes.root;
            default: n_out_item = it_side.early;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= it_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
